@@ rtl/core/mrfe_pkg.sv @@
// mrfe_pkg: shared types and constants of the factor energy evaluator
`timescale 1ns / 1ps

package mrfe_pkg;

    // item field widths
    localparam int unsigned IDX_W     = 19;
    localparam int unsigned COLOR_W   = 8;
    localparam int unsigned PIXEL_W   = 3 * COLOR_W;
    localparam int unsigned ENERGY_W  = 48;
    localparam int unsigned KIND_W    = 2;
    localparam int unsigned SIZE_W    = 9;
    localparam int unsigned WEIGHT_W  = 16;
    localparam int unsigned LAMBDA_W  = 32;

    // apb register window
    localparam int unsigned PADDR_W   = 5;
    localparam int unsigned PDATA_W   = 32;

    // divide by three through a reciprocal: floor(x/3) = (x*DIV3_MULT) >> DIV3_SHIFT
    localparam int unsigned DIV3_SHIFT  = IDX_W + 2;
    localparam int unsigned DIV3_MULT_W = IDX_W + 1;
    localparam logic [DIV3_MULT_W-1:0] DIV3_MULT =
        DIV3_MULT_W'(((64'd1 << DIV3_SHIFT) + 64'd2) / 64'd3);
    localparam int unsigned DIV3_PROD_W = IDX_W + DIV3_MULT_W;
    localparam int unsigned PIX_W       = DIV3_PROD_W - DIV3_SHIFT;

    typedef enum logic [KIND_W-1:0] {
        KIND_UNARY = 2'd0,
        KIND_HORIZ = 2'd1,
        KIND_VERT  = 2'd2,
        KIND_NONE  = 2'd3
    } kind_t;

    typedef enum logic {
        STATUS_OK  = 1'b0,
        STATUS_ERR = 1'b1
    } status_t;

    typedef enum logic {
        REQ_LOAD = 1'b0,
        REQ_EVAL = 1'b1
    } req_t;

    typedef enum logic [1:0] {
        CH_RED   = 2'd0,
        CH_GREEN = 2'd1,
        CH_BLUE  = 2'd2
    } chan_t;

    typedef enum logic [2:0] {
        REG_IMAGE_WIDTH  = 3'd0,
        REG_IMAGE_HEIGHT = 3'd1,
        REG_WEIGHT_RED   = 3'd2,
        REG_WEIGHT_GREEN = 3'd3,
        REG_WEIGHT_BLUE  = 3'd4,
        REG_BETA         = 3'd5,
        REG_LAMBDA       = 3'd6
    } cfg_reg_t;

    // one accepted input beat
    typedef struct packed {
        req_t                 req;
        logic [IDX_W-1:0]     idx;
        logic [COLOR_W-1:0]   label;
        logic [COLOR_W-1:0]   a_red;
        logic [COLOR_W-1:0]   a_green;
        logic [COLOR_W-1:0]   a_blue;
        logic [COLOR_W-1:0]   b_red;
        logic [COLOR_W-1:0]   b_green;
        logic [COLOR_W-1:0]   b_blue;
    } item_t;

endpackage

@@ rtl/core/mrfe_image_store.sv @@
// mrfe_image_store: single port image memory with registered read data
`timescale 1ns / 1ps

module mrfe_image_store #(
    parameter int unsigned DEPTH = 65536,
    localparam int unsigned ADDR_W = $clog2(DEPTH)
) (
    input  logic                         aclk,
    input  logic                         en,
    input  logic                         we,
    input  logic [ADDR_W-1:0]            addr,
    input  logic [mrfe_pkg::PIXEL_W-1:0] wdata,
    output logic [mrfe_pkg::PIXEL_W-1:0] rdata
);

    logic [mrfe_pkg::PIXEL_W-1:0] mem [DEPTH];
    logic [mrfe_pkg::PIXEL_W-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            if (we) begin
                mem[addr] <= wdata;
            end else begin
                rdata_reg <= mem[addr];
            end
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/core/mrf_factor_energy_eval_core.sv @@
// mrf_factor_energy_eval_core: pipelined factor energy evaluator with image store
`timescale 1ns / 1ps

// channel   | direction | handshake          | payload
// ----------+-----------+--------------------+-----------------------------------------
// s_*       | in        | s_valid / s_ready  | req_type, item_index, label, colors a, b
// m_*       | out       | m_valid / m_ready  | energy, factor_kind, status
// apb       | in/out    | psel / penable     | paddr, pwrite, pwdata, prdata, pready
//
// one beat per cycle sustained while m_ready holds; seven stage pipeline from the input
// register to the result register; the single port image memory is touched once per beat in stage 3
// aresetn is synchronous: clears all valid flags and loads register reset values
// a stalled output lets bubbles inside the pipeline close up before s_ready drops
// size thresholds follow a register write through area_reg and the offset registers

module mrf_factor_energy_eval_core #(
    parameter int unsigned MAX_WIDTH  = 256,
    parameter int unsigned MAX_HEIGHT = 256
) (
    input  logic                          aclk,
    input  logic                          aresetn,

    // input beats
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic                          s_req_type,
    input  logic [mrfe_pkg::IDX_W-1:0]    s_item_index,
    input  logic [mrfe_pkg::COLOR_W-1:0]  s_first_label,
    input  logic [mrfe_pkg::COLOR_W-1:0]  s_color_a_red,
    input  logic [mrfe_pkg::COLOR_W-1:0]  s_color_a_green,
    input  logic [mrfe_pkg::COLOR_W-1:0]  s_color_a_blue,
    input  logic [mrfe_pkg::COLOR_W-1:0]  s_color_b_red,
    input  logic [mrfe_pkg::COLOR_W-1:0]  s_color_b_green,
    input  logic [mrfe_pkg::COLOR_W-1:0]  s_color_b_blue,

    // result beats
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [mrfe_pkg::ENERGY_W-1:0] m_energy,
    output logic [mrfe_pkg::KIND_W-1:0]   m_factor_kind,
    output logic                          m_status,

    // register port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [mrfe_pkg::PADDR_W-1:0]  paddr,
    input  logic [mrfe_pkg::PDATA_W-1:0]  pwdata,
    output logic [mrfe_pkg::PDATA_W-1:0]  prdata,
    output logic                          pready
);

    // sizes of the geometry arithmetic
    localparam int unsigned W_BITS      = $clog2(MAX_WIDTH + 1);
    localparam int unsigned H_BITS      = $clog2(MAX_HEIGHT + 1);
    localparam int unsigned WH_BITS     = W_BITS + H_BITS;
    localparam int unsigned OFF_W       = WH_BITS + 3;
    localparam int unsigned CMP_W       = (OFF_W > mrfe_pkg::IDX_W) ? OFF_W : mrfe_pkg::IDX_W;
    localparam int unsigned STORE_DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int unsigned ADDR_W      = $clog2(STORE_DEPTH);
    localparam int unsigned SQ_W        = 2 * mrfe_pkg::COLOR_W;
    localparam int unsigned WPROD_W     = mrfe_pkg::WEIGHT_W + SQ_W;
    localparam int unsigned SUM_W       = WPROD_W + 2;
    localparam int unsigned BPROD_W     = mrfe_pkg::WEIGHT_W + SUM_W;

    localparam logic [CMP_W-1:0] STORE_LIMIT = CMP_W'(STORE_DEPTH);

    // stage numbering of the valid chain
    localparam int unsigned ST_IN   = 0;  // accepted beat
    localparam int unsigned ST_DIV  = 1;  // divide by three product
    localparam int unsigned ST_MEM  = 2;  // memory data, class known
    localparam int unsigned ST_SQ   = 3;  // squared differences
    localparam int unsigned ST_WP   = 4;  // weighted squares
    localparam int unsigned ST_SUM  = 5;  // channel sum
    localparam int unsigned ST_OUT  = 6;  // result register
    localparam int unsigned N_STAGE = 7;

    function automatic logic [SQ_W-1:0] sq_diff(
        input logic [mrfe_pkg::COLOR_W-1:0] p,
        input logic [mrfe_pkg::COLOR_W-1:0] q
    );
        logic [mrfe_pkg::COLOR_W-1:0] d;
        d = (p >= q) ? (p - q) : (q - p);
        return SQ_W'(d) * SQ_W'(d);
    endfunction

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    logic [mrfe_pkg::SIZE_W-1:0]   image_width_reg;
    logic [mrfe_pkg::SIZE_W-1:0]   image_height_reg;
    logic [mrfe_pkg::WEIGHT_W-1:0] weight_red_reg;
    logic [mrfe_pkg::WEIGHT_W-1:0] weight_green_reg;
    logic [mrfe_pkg::WEIGHT_W-1:0] weight_blue_reg;
    logic [mrfe_pkg::WEIGHT_W-1:0] beta_reg;
    logic [mrfe_pkg::LAMBDA_W-1:0] lambda_reg;

    mrfe_pkg::cfg_reg_t cfg_sel;
    logic               cfg_write;

    assign cfg_sel   = mrfe_pkg::cfg_reg_t'(paddr[4:2]);
    assign cfg_write = psel && penable && pwrite;
    assign pready    = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            image_width_reg  <= mrfe_pkg::SIZE_W'(256);
            image_height_reg <= mrfe_pkg::SIZE_W'(256);
            weight_red_reg   <= mrfe_pkg::WEIGHT_W'(256);
            weight_green_reg <= mrfe_pkg::WEIGHT_W'(256);
            weight_blue_reg  <= mrfe_pkg::WEIGHT_W'(256);
            beta_reg         <= mrfe_pkg::WEIGHT_W'(256);
            lambda_reg       <= mrfe_pkg::LAMBDA_W'(256);
        end else if (cfg_write) begin
            unique case (cfg_sel)
                mrfe_pkg::REG_IMAGE_WIDTH:  image_width_reg  <= pwdata[mrfe_pkg::SIZE_W-1:0];
                mrfe_pkg::REG_IMAGE_HEIGHT: image_height_reg <= pwdata[mrfe_pkg::SIZE_W-1:0];
                mrfe_pkg::REG_WEIGHT_RED:   weight_red_reg   <= pwdata[mrfe_pkg::WEIGHT_W-1:0];
                mrfe_pkg::REG_WEIGHT_GREEN: weight_green_reg <= pwdata[mrfe_pkg::WEIGHT_W-1:0];
                mrfe_pkg::REG_WEIGHT_BLUE:  weight_blue_reg  <= pwdata[mrfe_pkg::WEIGHT_W-1:0];
                mrfe_pkg::REG_BETA:         beta_reg         <= pwdata[mrfe_pkg::WEIGHT_W-1:0];
                mrfe_pkg::REG_LAMBDA:       lambda_reg       <= pwdata;
                default: ;  // unmapped slot
            endcase
        end
    end

    always_comb begin
        unique case (cfg_sel)
            mrfe_pkg::REG_IMAGE_WIDTH:  prdata = mrfe_pkg::PDATA_W'(image_width_reg);
            mrfe_pkg::REG_IMAGE_HEIGHT: prdata = mrfe_pkg::PDATA_W'(image_height_reg);
            mrfe_pkg::REG_WEIGHT_RED:   prdata = mrfe_pkg::PDATA_W'(weight_red_reg);
            mrfe_pkg::REG_WEIGHT_GREEN: prdata = mrfe_pkg::PDATA_W'(weight_green_reg);
            mrfe_pkg::REG_WEIGHT_BLUE:  prdata = mrfe_pkg::PDATA_W'(weight_blue_reg);
            mrfe_pkg::REG_BETA:         prdata = mrfe_pkg::PDATA_W'(beta_reg);
            mrfe_pkg::REG_LAMBDA:       prdata = lambda_reg;
            default:                    prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // factor index thresholds, two register steps behind the size registers
    // ------------------------------------------------------------------
    logic [W_BITS-1:0]  width_use_next,  width_use_reg;
    logic [H_BITS-1:0]  height_use_next, height_use_reg;
    logic [WH_BITS-1:0] area_reg;
    logic [OFF_W-1:0]   off_unary_reg;   // end of unary factors
    logic [OFF_W-1:0]   off_horiz_reg;   // end of horizontal edges
    logic [OFF_W-1:0]   off_vert_reg;    // end of vertical edges

    // saturate the sizes into [2, MAX]
    always_comb begin
        priority if (image_width_reg < mrfe_pkg::SIZE_W'(2)) begin
            width_use_next = W_BITS'(2);
        end else if (32'(image_width_reg) > MAX_WIDTH) begin
            width_use_next = W_BITS'(MAX_WIDTH);
        end else begin
            width_use_next = W_BITS'(image_width_reg);
        end
        priority if (image_height_reg < mrfe_pkg::SIZE_W'(2)) begin
            height_use_next = H_BITS'(2);
        end else if (32'(image_height_reg) > MAX_HEIGHT) begin
            height_use_next = H_BITS'(MAX_HEIGHT);
        end else begin
            height_use_next = H_BITS'(image_height_reg);
        end
    end

    always_ff @(posedge aclk) begin
        width_use_reg  <= width_use_next;
        height_use_reg <= height_use_next;
        area_reg       <= WH_BITS'(width_use_next) * WH_BITS'(height_use_next);
        // 3wh, 3wh + (w-1)h = 4wh - h, plus w(h-1) = 5wh - h - w
        off_unary_reg  <= OFF_W'(area_reg) + (OFF_W'(area_reg) << 1);
        off_horiz_reg  <= (OFF_W'(area_reg) << 2) - OFF_W'(height_use_reg);
        off_vert_reg   <= (OFF_W'(area_reg) << 2) + OFF_W'(area_reg)
                          - OFF_W'(height_use_reg) - OFF_W'(width_use_reg);
    end

    // ------------------------------------------------------------------
    // valid chain: a stage takes a beat when it is empty or its own moves on
    // ------------------------------------------------------------------
    logic [N_STAGE-1:0] stage_valid_reg;
    logic [N_STAGE-1:0] stage_ready;

    assign stage_ready[ST_OUT] = !stage_valid_reg[ST_OUT] || m_ready;
    assign stage_ready[ST_SUM] = !stage_valid_reg[ST_SUM] || stage_ready[ST_OUT];
    assign stage_ready[ST_WP]  = !stage_valid_reg[ST_WP]  || stage_ready[ST_SUM];
    assign stage_ready[ST_SQ]  = !stage_valid_reg[ST_SQ]  || stage_ready[ST_WP];
    assign stage_ready[ST_MEM] = !stage_valid_reg[ST_MEM] || stage_ready[ST_SQ];
    assign stage_ready[ST_DIV] = !stage_valid_reg[ST_DIV] || stage_ready[ST_MEM];
    assign stage_ready[ST_IN]  = !stage_valid_reg[ST_IN]  || stage_ready[ST_DIV];

    assign s_ready = stage_ready[ST_IN];
    assign m_valid = stage_valid_reg[ST_OUT];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stage_valid_reg <= '0;
        end else begin
            if (stage_ready[ST_IN])  stage_valid_reg[ST_IN]  <= s_valid;
            if (stage_ready[ST_DIV]) stage_valid_reg[ST_DIV] <= stage_valid_reg[ST_IN];
            if (stage_ready[ST_MEM]) stage_valid_reg[ST_MEM] <= stage_valid_reg[ST_DIV];
            if (stage_ready[ST_SQ])  stage_valid_reg[ST_SQ]  <= stage_valid_reg[ST_MEM];
            if (stage_ready[ST_WP])  stage_valid_reg[ST_WP]  <= stage_valid_reg[ST_SQ];
            if (stage_ready[ST_SUM]) stage_valid_reg[ST_SUM] <= stage_valid_reg[ST_WP];
            if (stage_ready[ST_OUT]) stage_valid_reg[ST_OUT] <= stage_valid_reg[ST_SUM];
        end
    end

    // ------------------------------------------------------------------
    // stage 1: input register
    // ------------------------------------------------------------------
    mrfe_pkg::item_t in_item_reg;

    always_ff @(posedge aclk) begin
        if (stage_ready[ST_IN]) begin
            in_item_reg.req     <= mrfe_pkg::req_t'(s_req_type);
            in_item_reg.idx     <= s_item_index;
            in_item_reg.label   <= s_first_label;
            in_item_reg.a_red   <= s_color_a_red;
            in_item_reg.a_green <= s_color_a_green;
            in_item_reg.a_blue  <= s_color_a_blue;
            in_item_reg.b_red   <= s_color_b_red;
            in_item_reg.b_green <= s_color_b_green;
            in_item_reg.b_blue  <= s_color_b_blue;
        end
    end

    // ------------------------------------------------------------------
    // stage 2: index times reciprocal of three
    // ------------------------------------------------------------------
    mrfe_pkg::item_t                   div_item_reg;
    logic [mrfe_pkg::DIV3_PROD_W-1:0]  div_prod_reg;

    always_ff @(posedge aclk) begin
        if (stage_ready[ST_DIV]) begin
            div_item_reg <= in_item_reg;
            div_prod_reg <= mrfe_pkg::DIV3_PROD_W'(in_item_reg.idx)
                            * mrfe_pkg::DIV3_PROD_W'(mrfe_pkg::DIV3_MULT);
        end
    end

    // pixel number and channel; the channel is idx - 3*pix, known below four
    logic [mrfe_pkg::PIX_W-1:0] pix;
    logic [1:0]                 chan;
    logic [CMP_W-1:0]           idx_cmp;
    logic                       is_eval;
    logic                       load_in_range;
    mrfe_pkg::kind_t            kind_next;
    mrfe_pkg::status_t          status_next;

    assign pix     = div_prod_reg[mrfe_pkg::DIV3_SHIFT +: mrfe_pkg::PIX_W];
    assign chan    = div_item_reg.idx[1:0] - 2'(pix[1:0] * 2'd3);
    assign idx_cmp = CMP_W'(div_item_reg.idx);
    assign is_eval = (div_item_reg.req == mrfe_pkg::REQ_EVAL);
    assign load_in_range = idx_cmp < STORE_LIMIT;

    // factor class against the size thresholds
    always_comb begin
        kind_next   = mrfe_pkg::KIND_NONE;
        status_next = mrfe_pkg::STATUS_OK;
        priority if (!is_eval) begin
            kind_next = mrfe_pkg::KIND_NONE;
        end else if (idx_cmp < CMP_W'(off_unary_reg)) begin
            kind_next = mrfe_pkg::KIND_UNARY;
        end else if (idx_cmp < CMP_W'(off_horiz_reg)) begin
            kind_next = mrfe_pkg::KIND_HORIZ;
        end else if (idx_cmp < CMP_W'(off_vert_reg)) begin
            kind_next = mrfe_pkg::KIND_VERT;
        end else begin
            status_next = mrfe_pkg::STATUS_ERR;
        end
    end

    // one memory access per beat as it moves into stage 3: a load inside the store writes,
    // anything else reads; program order is kept because only one beat sits here
    logic                         mem_en;
    logic                         mem_we;
    logic [ADDR_W-1:0]            mem_addr;
    logic [mrfe_pkg::PIXEL_W-1:0] mem_wdata;
    logic [mrfe_pkg::PIXEL_W-1:0] mem_rdata;

    assign mem_en    = stage_ready[ST_MEM] && stage_valid_reg[ST_DIV];
    assign mem_we    = !is_eval && load_in_range;
    assign mem_addr  = is_eval ? ADDR_W'(pix) : ADDR_W'(div_item_reg.idx);
    assign mem_wdata = {div_item_reg.a_blue, div_item_reg.a_green, div_item_reg.a_red};

    mrfe_image_store #(
        .DEPTH (STORE_DEPTH)
    ) u_image_store (
        .aclk  (aclk),
        .en    (mem_en),
        .we    (mem_we),
        .addr  (mem_addr),
        .wdata (mem_wdata),
        .rdata (mem_rdata)
    );

    // ------------------------------------------------------------------
    // stage 3: class registered alongside the memory read data
    // ------------------------------------------------------------------
    mrfe_pkg::item_t   mem_item_reg;
    mrfe_pkg::kind_t   mem_kind_reg;
    mrfe_pkg::status_t mem_status_reg;
    logic [1:0]        mem_chan_reg;

    always_ff @(posedge aclk) begin
        if (stage_ready[ST_MEM]) begin
            mem_item_reg   <= div_item_reg;
            mem_kind_reg   <= kind_next;
            mem_status_reg <= status_next;
            mem_chan_reg   <= chan;
        end
    end

    logic [mrfe_pkg::COLOR_W-1:0] stored_color;
    logic [SQ_W-1:0]              sq_unary;
    logic [SQ_W-1:0]              sq_red_next, sq_green_next, sq_blue_next;

    always_comb begin
        unique case (mrfe_pkg::chan_t'(mem_chan_reg))
            mrfe_pkg::CH_RED:   stored_color = mem_rdata[0 +: mrfe_pkg::COLOR_W];
            mrfe_pkg::CH_GREEN: stored_color = mem_rdata[mrfe_pkg::COLOR_W +: mrfe_pkg::COLOR_W];
            mrfe_pkg::CH_BLUE:  stored_color = mem_rdata[2*mrfe_pkg::COLOR_W +: mrfe_pkg::COLOR_W];
            default:            stored_color = '0;
        endcase
        sq_unary = sq_diff(stored_color, mem_item_reg.label);

        // a unary factor uses one lane only, the others stay at zero
        if (mem_kind_reg == mrfe_pkg::KIND_UNARY) begin
            sq_red_next   = (mem_chan_reg == mrfe_pkg::CH_RED)   ? sq_unary : '0;
            sq_green_next = (mem_chan_reg == mrfe_pkg::CH_GREEN) ? sq_unary : '0;
            sq_blue_next  = (mem_chan_reg == mrfe_pkg::CH_BLUE)  ? sq_unary : '0;
        end else begin
            sq_red_next   = sq_diff(mem_item_reg.b_red,   mem_item_reg.a_red);
            sq_green_next = sq_diff(mem_item_reg.b_green, mem_item_reg.a_green);
            sq_blue_next  = sq_diff(mem_item_reg.b_blue,  mem_item_reg.a_blue);
        end
    end

    // ------------------------------------------------------------------
    // stage 4: squared differences
    // ------------------------------------------------------------------
    mrfe_pkg::kind_t   sq_kind_reg;
    mrfe_pkg::status_t sq_status_reg;
    logic              sq_cut_reg;
    logic [SQ_W-1:0]   sq_red_reg, sq_green_reg, sq_blue_reg;

    always_ff @(posedge aclk) begin
        if (stage_ready[ST_SQ]) begin
            sq_kind_reg   <= mem_kind_reg;
            sq_status_reg <= mem_status_reg;
            sq_cut_reg    <= (mem_item_reg.label != '0);
            sq_red_reg    <= sq_red_next;
            sq_green_reg  <= sq_green_next;
            sq_blue_reg   <= sq_blue_next;
        end
    end

    // ------------------------------------------------------------------
    // stage 5: weight times square, one multiplier per channel
    // ------------------------------------------------------------------
    mrfe_pkg::kind_t   wp_kind_reg;
    mrfe_pkg::status_t wp_status_reg;
    logic              wp_cut_reg;
    logic [WPROD_W-1:0] wp_red_reg, wp_green_reg, wp_blue_reg;

    always_ff @(posedge aclk) begin
        if (stage_ready[ST_WP]) begin
            wp_kind_reg   <= sq_kind_reg;
            wp_status_reg <= sq_status_reg;
            wp_cut_reg    <= sq_cut_reg;
            wp_red_reg    <= WPROD_W'(weight_red_reg)   * WPROD_W'(sq_red_reg);
            wp_green_reg  <= WPROD_W'(weight_green_reg) * WPROD_W'(sq_green_reg);
            wp_blue_reg   <= WPROD_W'(weight_blue_reg)  * WPROD_W'(sq_blue_reg);
        end
    end

    // ------------------------------------------------------------------
    // stage 6: channel sum
    // ------------------------------------------------------------------
    mrfe_pkg::kind_t   sum_kind_reg;
    mrfe_pkg::status_t sum_status_reg;
    logic              sum_cut_reg;
    logic [SUM_W-1:0]  sum_reg;

    always_ff @(posedge aclk) begin
        if (stage_ready[ST_SUM]) begin
            sum_kind_reg   <= wp_kind_reg;
            sum_status_reg <= wp_status_reg;
            sum_cut_reg    <= wp_cut_reg;
            sum_reg        <= SUM_W'(wp_red_reg) + SUM_W'(wp_green_reg) + SUM_W'(wp_blue_reg);
        end
    end

    // ------------------------------------------------------------------
    // stage 7: beta scaling and result selection
    // ------------------------------------------------------------------
    logic [BPROD_W-1:0]            beta_prod;
    logic [mrfe_pkg::ENERGY_W-1:0] energy_next;
    logic [mrfe_pkg::ENERGY_W-1:0] energy_out_reg;
    mrfe_pkg::kind_t               kind_out_reg;
    mrfe_pkg::status_t             status_out_reg;

    assign beta_prod = BPROD_W'(beta_reg) * BPROD_W'(sum_reg);

    always_comb begin
        unique case (sum_kind_reg)
            mrfe_pkg::KIND_UNARY: energy_next = mrfe_pkg::ENERGY_W'(sum_reg);
            mrfe_pkg::KIND_HORIZ,
            mrfe_pkg::KIND_VERT: begin
                // a cut edge costs lambda, otherwise truncated beta-scaled sum
                energy_next = sum_cut_reg ? mrfe_pkg::ENERGY_W'(lambda_reg)
                                          : mrfe_pkg::ENERGY_W'(beta_prod >> 8);
            end
            default:              energy_next = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (stage_ready[ST_OUT]) begin
            energy_out_reg <= energy_next;
            kind_out_reg   <= sum_kind_reg;
            status_out_reg <= sum_status_reg;
        end
    end

    assign m_energy      = energy_out_reg;
    assign m_factor_kind = kind_out_reg;
    assign m_status      = status_out_reg;

endmodule

@@ rtl/core/mrfe_checker.sv @@
// mrfe_checker: port level checks on result beats, bound to the core
`timescale 1ns / 1ps

module mrfe_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          m_valid,
    input logic                          m_ready,
    input logic [mrfe_pkg::ENERGY_W-1:0] m_energy,
    input logic [mrfe_pkg::KIND_W-1:0]   m_factor_kind,
    input logic                          m_status
);

    // an error beat carries no factor class
    a_err_no_kind: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_status == mrfe_pkg::STATUS_ERR)
            |-> (m_factor_kind == mrfe_pkg::KIND_NONE))
        else $error("error beat with factor class");

    // loads and errors answer zero energy
    a_none_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_factor_kind == mrfe_pkg::KIND_NONE) |-> (m_energy == '0))
        else $error("nonzero energy without factor");

    // unary energy is a 16 bit weight times a 16 bit square
    a_unary_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_factor_kind == mrfe_pkg::KIND_UNARY)
            |-> (m_energy[mrfe_pkg::ENERGY_W-1:32] == '0))
        else $error("unary energy out of range");

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_energy)
            && $stable(m_factor_kind) && $stable(m_status)))
        else $error("result beat changed while stalled");

endmodule

bind mrf_factor_energy_eval_core mrfe_checker u_mrfe_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_energy      (m_energy),
    .m_factor_kind (m_factor_kind),
    .m_status      (m_status)
);
